FILE: design/mtwb_pkg.sv
// shared types and constants for the mt19937 word and bounded draw unit
package mtwb_pkg;

  localparam int unsigned N_WORDS   = 624;
  localparam int unsigned M_OFFSET  = 397;
  localparam logic [31:0] TWIST_MAT = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT  = 32'h80000000;
  localparam logic [31:0] LOW_BITS  = 32'h7fffffff;
  localparam logic [31:0] MUL_LIN   = 32'd1812433253;
  localparam logic [31:0] MUL_MIX1  = 32'd1664525;
  localparam logic [31:0] MUL_MIX2  = 32'd1566083941;
  localparam logic [31:0] SEED_LIN  = 32'd19650218;

  typedef enum logic [1:0] {
    ACT_WORD   = 2'd0,
    ACT_BOUND  = 2'd1,
    ACT_RESEED = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // datapath operation selector
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LIN,
    OP_MIX1,
    OP_MIX2,
    OP_FIX0,
    OP_TWIST,
    OP_DRAW
  } op_t;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_LIN,
    ST_MIX1,
    ST_MIX2,
    ST_FIX0,
    ST_IDLE,
    ST_REQ,
    ST_TWIST,
    ST_WAIT,
    ST_CHECK,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic need_twist;
    logic [31:0] word;
  } sts_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: design/mtwb_ram.sv
// generic single-write dual-read ram with registered read
module mtwb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: design/mtwb_datapath.sv
// state memory, seeding, twisting and draw sequencer datapath
module mtwb_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       seed_value,
  input  mtwb_pkg::cmd_t    cmd,
  output mtwb_pkg::sts_t    sts
);

  localparam int AW = $clog2(mtwb_pkg::N_WORDS);
  localparam logic [AW-1:0] LAST = AW'(mtwb_pkg::N_WORDS - 1);

  // ram ports
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [31:0]   wdata, da, db;

  mtwb_ram #(.WIDTH(32), .DEPTH(mtwb_pkg::N_WORDS)) u_ram (
    .clk, .we, .waddr, .wdata,
    .raddr_a(ra), .rdata_a(da), .raddr_b(rb), .rdata_b(db)
  );

  mtwb_pkg::op_t op;
  logic [1:0]    phase;      // twist: 2 prefetch, 3 load word 0, 0 issue reads, 1 write
  logic [AW-1:0] idx;        // word being produced
  logic [9:0]    cnt;        // remaining steps of a mix pass
  logic          jk;         // key index
  logic [31:0]   prev;       // last written word
  logic [31:0]   cur;        // old value of the word being twisted
  logic [31:0]   prod;
  logic [AW-1:0] word_index;
  logic          done;
  logic [31:0]   word;

  logic [31:0] pmix, key_w, tw_y, tw_res;
  logic        klen2;
  logic [AW-1:0] nx_idx, far_idx;

  assign klen2 = |seed_value[63:32];
  assign key_w = jk ? seed_value[63:32] : seed_value[31:0];
  assign pmix  = prev ^ (prev >> 30);
  assign nx_idx  = (idx == LAST) ? '0 : idx + AW'(1);
  assign far_idx = (idx >= AW'(mtwb_pkg::N_WORDS - mtwb_pkg::M_OFFSET)) ?
                   idx - AW'(mtwb_pkg::N_WORDS - mtwb_pkg::M_OFFSET) :
                   idx + AW'(mtwb_pkg::M_OFFSET);
  assign tw_y   = (cur & mtwb_pkg::HIGH_BIT) | (da & mtwb_pkg::LOW_BITS);
  assign tw_res = db ^ (tw_y >> 1) ^ (tw_y[0] ? mtwb_pkg::TWIST_MAT : 32'd0);

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = '0;
    ra = idx;
    rb = idx;
    case (op)
      mtwb_pkg::OP_LIN: begin
        we = (idx == '0) || (phase == 2'd1);
        wdata = (idx == '0) ? mtwb_pkg::SEED_LIN : prod + 32'(idx);
      end
      mtwb_pkg::OP_MIX1: begin
        we = (phase == 2'd1);
        wdata = (da ^ prod) + key_w + 32'(jk);
      end
      mtwb_pkg::OP_MIX2: begin
        we = (phase == 2'd1);
        wdata = (da ^ prod) - 32'(idx);
      end
      mtwb_pkg::OP_FIX0: begin
        we = 1'b1;
        waddr = '0;
        wdata = mtwb_pkg::HIGH_BIT;
      end
      mtwb_pkg::OP_TWIST: begin
        ra = (phase == 2'd2) ? idx : nx_idx;
        rb = far_idx;
        we = (phase == 2'd1);
        wdata = tw_res;
      end
      mtwb_pkg::OP_DRAW: begin
        ra = word_index;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= mtwb_pkg::OP_IDLE;
      phase <= '0;
      idx <= '0;
      cnt <= '0;
      jk <= 1'b0;
      prev <= '0;
      cur <= '0;
      prod <= '0;
      word <= '0;
      done <= 1'b0;
      word_index <= AW'(mtwb_pkg::N_WORDS);
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        op <= cmd.op;
        phase <= (cmd.op == mtwb_pkg::OP_TWIST) ? 2'd2 : 2'd0;
        case (cmd.op)
          mtwb_pkg::OP_LIN, mtwb_pkg::OP_TWIST: idx <= '0;
          mtwb_pkg::OP_MIX1: begin
            // word 0 holds the linear seed when the first mix pass begins
            idx <= AW'(1);
            jk <= 1'b0;
            cnt <= 10'(mtwb_pkg::N_WORDS);
            prev <= mtwb_pkg::SEED_LIN;
          end
          // second pass continues from where the first one stopped
          mtwb_pkg::OP_MIX2: cnt <= 10'(mtwb_pkg::N_WORDS - 1);
          default: ;
        endcase
      end else begin
        case (op)
          mtwb_pkg::OP_LIN: begin
            if (idx == '0) begin
              prev <= mtwb_pkg::SEED_LIN;
              idx <= AW'(1);
            end else if (phase == 2'd0) begin
              prod <= mtwb_pkg::MUL_LIN * pmix;
              phase <= 2'd1;
            end else begin
              prev <= wdata;
              phase <= 2'd0;
              if (idx == LAST) begin
                op <= mtwb_pkg::OP_IDLE;
                done <= 1'b1;
              end else begin
                idx <= idx + AW'(1);
              end
            end
          end
          mtwb_pkg::OP_MIX1, mtwb_pkg::OP_MIX2: begin
            if (phase == 2'd0) begin
              prod <= pmix * ((op == mtwb_pkg::OP_MIX1) ? mtwb_pkg::MUL_MIX1
                                                         : mtwb_pkg::MUL_MIX2);
              phase <= 2'd1;
            end else begin
              // on wrap word 0 is not rewritten; prev already holds the last word, which stands for it
              prev <= wdata;
              phase <= 2'd0;
              jk <= klen2 ? ~jk : 1'b0;
              cnt <= cnt - 10'd1;
              idx <= (idx == LAST) ? AW'(1) : idx + AW'(1);
              if (cnt == 10'd1) begin
                op <= mtwb_pkg::OP_IDLE;
                done <= 1'b1;
              end
            end
          end
          mtwb_pkg::OP_FIX0: begin
            op <= mtwb_pkg::OP_IDLE;
            done <= 1'b1;
            word_index <= AW'(mtwb_pkg::N_WORDS);
          end
          mtwb_pkg::OP_TWIST: begin
            case (phase)
              2'd2: phase <= 2'd3;
              2'd3: begin
                cur <= da;
                phase <= 2'd0;
              end
              2'd0: phase <= 2'd1;
              default: begin
                // next word's old value was just read through port a
                cur <= da;
                phase <= 2'd0;
                if (idx == LAST) begin
                  op <= mtwb_pkg::OP_IDLE;
                  done <= 1'b1;
                  word_index <= '0;
                end else begin
                  idx <= idx + AW'(1);
                end
              end
            endcase
          end
          mtwb_pkg::OP_DRAW: begin
            if (phase == 2'd0) begin
              phase <= 2'd1;
            end else begin
              word <= mtwb_pkg::temper(da);
              word_index <= word_index + AW'(1);
              op <= mtwb_pkg::OP_IDLE;
              done <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign sts.done = done;
  assign sts.need_twist = (word_index >= AW'(mtwb_pkg::N_WORDS));
  assign sts.word = word;

endmodule

FILE: design/mtwb_ctrl.sv
// controller state machine for seeding, drawing and rejection
module mtwb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_action,
  input  logic [30:0]    in_bound,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_value,
  output mtwb_pkg::cmd_t cmd,
  input  mtwb_pkg::sts_t sts
);

  mtwb_pkg::state_t state, state_next;
  logic [30:0] bnd;
  logic [4:0]  shift;
  logic        bounded;
  logic        reseeding;
  logic [31:0] res;
  logic [31:0] cand;
  logic [5:0]  blen;

  always_comb begin
    blen = 6'd0;
    for (int b = 0; b < 31; b++) begin
      if (in_bound[b]) blen = 6'(b + 1);
    end
  end

  assign cand = sts.word >> shift;
  assign in_ready = (state == mtwb_pkg::ST_IDLE);
  assign out_valid = (state == mtwb_pkg::ST_OUT);
  assign out_value = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtwb_pkg::ST_BOOT;
      bnd <= '0;
      shift <= '0;
      bounded <= 1'b0;
      reseeding <= 1'b0;
      res <= '0;
    end else begin
      state <= state_next;
      if (state == mtwb_pkg::ST_IDLE && in_valid) begin
        bnd <= in_bound;
        shift <= 5'(6'd32 - blen);
        bounded <= (mtwb_pkg::action_t'(in_action) == mtwb_pkg::ACT_BOUND);
        reseeding <= (mtwb_pkg::action_t'(in_action) == mtwb_pkg::ACT_RESEED);
        res <= '0;
      end else if (state == mtwb_pkg::ST_CHECK) begin
        res <= bounded ? cand : sts.word;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{op: mtwb_pkg::OP_IDLE, start: 1'b0};
    case (state)
      mtwb_pkg::ST_BOOT: begin
        cmd = '{op: mtwb_pkg::OP_LIN, start: 1'b1};
        state_next = mtwb_pkg::ST_LIN;
      end
      mtwb_pkg::ST_LIN: begin
        if (sts.done) begin
          cmd = '{op: mtwb_pkg::OP_MIX1, start: 1'b1};
          state_next = mtwb_pkg::ST_MIX1;
        end
      end
      mtwb_pkg::ST_MIX1: begin
        if (sts.done) begin
          cmd = '{op: mtwb_pkg::OP_MIX2, start: 1'b1};
          state_next = mtwb_pkg::ST_MIX2;
        end
      end
      mtwb_pkg::ST_MIX2: begin
        if (sts.done) begin
          cmd = '{op: mtwb_pkg::OP_FIX0, start: 1'b1};
          state_next = mtwb_pkg::ST_FIX0;
        end
      end
      mtwb_pkg::ST_FIX0: begin
        // seeding after reset gives no word
        if (sts.done) state_next = reseeding ? mtwb_pkg::ST_OUT : mtwb_pkg::ST_IDLE;
      end
      mtwb_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (mtwb_pkg::action_t'(in_action))
            mtwb_pkg::ACT_WORD: state_next = mtwb_pkg::ST_REQ;
            mtwb_pkg::ACT_BOUND:
              state_next = (in_bound == '0) ? mtwb_pkg::ST_OUT : mtwb_pkg::ST_REQ;
            mtwb_pkg::ACT_RESEED: begin
              state_next = mtwb_pkg::ST_LIN;
              cmd = '{op: mtwb_pkg::OP_LIN, start: 1'b1};
            end
            default: state_next = mtwb_pkg::ST_OUT;
          endcase
        end
      end
      mtwb_pkg::ST_REQ: begin
        if (sts.need_twist) begin
          cmd = '{op: mtwb_pkg::OP_TWIST, start: 1'b1};
          state_next = mtwb_pkg::ST_TWIST;
        end else begin
          cmd = '{op: mtwb_pkg::OP_DRAW, start: 1'b1};
          state_next = mtwb_pkg::ST_WAIT;
        end
      end
      mtwb_pkg::ST_TWIST: if (sts.done) state_next = mtwb_pkg::ST_REQ;
      mtwb_pkg::ST_WAIT: if (sts.done) state_next = mtwb_pkg::ST_CHECK;
      mtwb_pkg::ST_CHECK:
        state_next = (bounded && cand >= {1'b0, bnd}) ? mtwb_pkg::ST_REQ
                                                      : mtwb_pkg::ST_OUT;
      mtwb_pkg::ST_OUT: if (out_ready) state_next = mtwb_pkg::ST_IDLE;
      default: state_next = mtwb_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != mtwb_pkg::ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("result dropped");
  a_bound_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bounded && bnd != '0) |-> (res < {1'b0, bnd}))
    else $error("bounded result out of range");
`endif

endmodule

FILE: design/mt19937_word_and_bounded_draw_unit.sv
// top level of the mt19937 word and bounded draw unit
// plain draw: after acceptance the unit passes through request, wait and check before m_tvalid rises
// a draw that finds all 624 words used first twists them in place
// each rejected bounded candidate is redrawn, with a twist first when one falls due
// reseed gives its word after three passes (linear, first mix, second mix) and the word 0 fix
// rst seeds from seed value 0; s_tready rises once that seeding is done
module mt19937_word_and_bounded_draw_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // bound[30:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // value[31:0]
);

  logic [63:0] seed_value;
  mtwb_pkg::cmd_t cmd;
  mtwb_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) seed_value <= '0;
    else if (cfg_we) seed_value <= cfg_wdata;
  end

  mtwb_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_action(s_tuser), .in_bound(s_tdata[30:0]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_value(m_tdata),
    .cmd, .sts
  );

  mtwb_datapath u_dp (.clk, .rst, .seed_value, .cmd, .sts);

endmodule
